[src/pmtsp_pkg.sv]
// ----------------------------------------------------------------------------
// pmtsp_pkg
// Shared types and constants of the program map section parser.
// ----------------------------------------------------------------------------
package pmtsp_pkg;

  // Program table size and derived widths
  localparam int MAX_PROGRAMS = 16;
  localparam int PROG_IDX_W   = (MAX_PROGRAMS > 1) ? $clog2(MAX_PROGRAMS) : 1;
  localparam int PROG_CNT_W   = $clog2(MAX_PROGRAMS + 1);

  // Field widths
  localparam int BYTE_W     = 8;
  localparam int POS_W      = 13;
  localparam int LEN_W      = 12;
  localparam int PROG_W     = 16;
  localparam int PID_W      = 13;
  localparam int KIND_W     = 2;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W  = OUT_TDATA_W - PROG_W - PID_W - 1;

  // Configuration port
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_VIDEO_CODE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_AUDIO_CODE = 1'b1;
  localparam logic [BYTE_W-1:0] VIDEO_CODE_RST = 8'h02;
  localparam logic [BYTE_W-1:0] AUDIO_CODE_RST = 8'h03;

  // Section layout
  localparam logic [BYTE_W-1:0] PMT_TABLE_ID = 8'h02;
  localparam logic [POS_W-1:0]  POS_FIRST    = 13'd1;
  localparam logic [POS_W-1:0]  POS_SLEN_HI  = 13'd1;
  localparam logic [POS_W-1:0]  POS_SLEN_LO  = 13'd2;
  localparam logic [POS_W-1:0]  POS_PROG_HI  = 13'd3;
  localparam logic [POS_W-1:0]  POS_PROG_LO  = 13'd4;
  localparam logic [POS_W-1:0]  POS_INFO_HI  = 13'd10;
  localparam logic [POS_W-1:0]  POS_INFO_LO  = 13'd11;
  localparam logic [POS_W-1:0]  POS_MAX      = 13'd8191;

  // Report kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_VIDEO  = 2'd0,
    KIND_AUDIO  = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_DONE   = 2'd3
  } kind_t;

  // Request from the byte parser to the program table
  typedef struct packed {
    kind_t             kind;
    logic [PROG_W-1:0] prog_num;
    logic [PID_W-1:0]  pid;
  } cmd_t;

  localparam int CMD_DEPTH = 2;

endpackage

[src/pmt_section_parser_core.sv]
// ----------------------------------------------------------------------------
// pmt_section_parser_core
// Program map section parser: reports first video/audio stream per program, section end and reject.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                                   | tuser
//  in_     | slave     | [7:0] section_byte                      | [0] first_byte
//  out_    | master    | [15:0] program_number, [28:16]          | [1:0] report_kind
//          |           | stream_pid, [29] table_full, [31:30] 0  |
//  cfg_    | write     | cfg_addr 0 video_type_code, 1 audio_type_code
//
// One section byte is taken per cycle while the two-entry request queue has
// room; the byte parser never waits on the program table otherwise.
// A request at the head of the queue is looked up in the program table and any report
// it yields is held in the output register; one lookup per cycle while the output is not stalled.
// Reset (synchronous, rst_n low) empties the queue and the program table.
// A stalled output holds its report and, once the queue fills, stalls input.
// ----------------------------------------------------------------------------
module pmt_section_parser_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [pmtsp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [pmtsp_pkg::BYTE_W-1:0]          cfg_wdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [pmtsp_pkg::BYTE_W-1:0]          in_tdata,   // [7:0] section_byte
  input  logic [0:0]                            in_tuser,   // [0] first_byte
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [15:0] program_number, [28:16] stream_pid, [29] table_full
  output logic [pmtsp_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [pmtsp_pkg::KIND_W-1:0]          out_tuser   // [1:0] report_kind
);
  import pmtsp_pkg::*;

  logic              fifo_full, byte_accept, push, cmd_valid, cmd_pop, out_full;
  cmd_t              push_cmd, head_cmd;
  logic [PROG_W-1:0] out_program;
  logic [PID_W-1:0]  out_pid;

  assign in_tready   = !fifo_full;
  assign byte_accept = in_tvalid && !fifo_full;

  pmtsp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .byte_accept  (byte_accept),
    .section_byte (in_tdata),
    .first_byte   (in_tuser[0]),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  pmtsp_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (cmd_pop),
    .valid    (cmd_valid),
    .pop_cmd  (head_cmd)
  );

  pmtsp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd         (head_cmd),
    .cmd_pop     (cmd_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_kind    (out_tuser),
    .out_program (out_program),
    .out_pid     (out_pid),
    .out_full    (out_full)
  );

  // Pack the report
  assign out_tdata = {{OUT_PAD_W{1'b0}}, out_full, out_pid, out_program};

endmodule

[src/pmtsp_front.sv]
// ----------------------------------------------------------------------------
// pmtsp_front
// Byte parser: walks header, descriptors and stream loop, emits requests.
// ----------------------------------------------------------------------------
module pmtsp_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pmtsp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [pmtsp_pkg::BYTE_W-1:0]        cfg_wdata,
  input  logic                                byte_accept,
  input  logic [pmtsp_pkg::BYTE_W-1:0]        section_byte,
  input  logic                                first_byte,
  output logic                                push,
  output pmtsp_pkg::cmd_t                     push_cmd
);
  import pmtsp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEADER, PH_SKIP, PH_TYPE, PH_PID_HI, PH_PID_LO, PH_LEN_HI, PH_LEN_LO
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt, pos_inc;
  logic [LEN_W-1:0]    slen_r, slen_nxt, sec_end;
  logic [PROG_W-1:0]   prog_r, prog_nxt;
  logic [LEN_W-1:0]    info_r, info_nxt, info_full;
  logic [BYTE_W-1:0]   type_r, type_nxt;
  logic [PID_W-1:0]    pid_r, pid_nxt, pid_full;
  logic [LEN_W-1:0]    skip_r, skip_nxt, skip_full;
  logic [BYTE_W-1:0]   video_code_r, video_code_nxt;
  logic [BYTE_W-1:0]   audio_code_r, audio_code_nxt;
  logic                at_boundary;

  // Section end excludes the four CRC bytes
  assign sec_end = (slen_r != '0) ? slen_r - LEN_W'(1) : '0;
  assign pos_inc = (pos_r < POS_MAX) ? pos_r + POS_W'(1) : pos_r;
  assign info_full = {info_r[LEN_W-1:BYTE_W], section_byte};
  assign pid_full  = {pid_r[PID_W-1:BYTE_W], section_byte};
  assign skip_full = {skip_r[LEN_W-1:BYTE_W], section_byte};

  always_comb begin
    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    slen_nxt       = slen_r;
    prog_nxt       = prog_r;
    info_nxt       = info_r;
    type_nxt       = type_r;
    pid_nxt        = pid_r;
    skip_nxt       = skip_r;
    video_code_nxt = video_code_r;
    audio_code_nxt = audio_code_r;
    at_boundary    = 1'b0;
    push           = 1'b0;
    push_cmd       = '{kind: KIND_DONE, prog_num: prog_r, pid: '0};

    // Write configuration registers
    if (cfg_we) begin
      case (cfg_addr)
        CFG_VIDEO_CODE: video_code_nxt = cfg_wdata;
        CFG_AUDIO_CODE: audio_code_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (byte_accept && first_byte) begin
      // Start a new section, drop anything in progress
      slen_nxt = '0;
      prog_nxt = '0;
      info_nxt = '0;
      type_nxt = '0;
      pid_nxt  = '0;
      skip_nxt = '0;
      pos_nxt  = POS_FIRST;
      if (section_byte != PMT_TABLE_ID) begin
        phase_nxt = PH_IDLE;
        push      = 1'b1;
        push_cmd  = '{kind: KIND_REJECT, prog_num: '0, pid: '0};
      end else begin
        phase_nxt = PH_HEADER;
      end
    end else if (byte_accept && phase_r != PH_IDLE) begin
      pos_nxt = pos_inc;
      case (phase_r)
        PH_HEADER: begin
          if (pos_r == POS_SLEN_HI) begin
            slen_nxt = {section_byte[3:0], 8'h00};
          end else if (pos_r == POS_SLEN_LO) begin
            slen_nxt = {slen_r[LEN_W-1:BYTE_W], section_byte};
          end else if (pos_r == POS_PROG_HI) begin
            prog_nxt = {section_byte, 8'h00};
          end else if (pos_r == POS_PROG_LO) begin
            prog_nxt = {prog_r[PROG_W-1:BYTE_W], section_byte};
          end else if (pos_r == POS_INFO_HI) begin
            info_nxt = {section_byte[3:0], 8'h00};
          end else if (pos_r >= POS_INFO_LO) begin
            info_nxt = info_full;
            if (info_full != '0) begin
              skip_nxt  = info_full;
              phase_nxt = PH_SKIP;
            end else begin
              at_boundary = 1'b1;
            end
          end
        end
        PH_SKIP: begin
          if (skip_r > LEN_W'(1)) begin
            skip_nxt = skip_r - LEN_W'(1);
          end else begin
            skip_nxt    = '0;
            at_boundary = 1'b1;
          end
        end
        PH_TYPE: begin
          type_nxt  = section_byte;
          phase_nxt = PH_PID_HI;
        end
        PH_PID_HI: begin
          pid_nxt   = {section_byte[4:0], 8'h00};
          phase_nxt = PH_PID_LO;
        end
        PH_PID_LO: begin
          // Classify the stream; video wins when both codes match
          pid_nxt   = pid_full;
          phase_nxt = PH_LEN_HI;
          if (type_r == video_code_r) begin
            push     = 1'b1;
            push_cmd = '{kind: KIND_VIDEO, prog_num: prog_r, pid: pid_full};
          end else if (type_r == audio_code_r) begin
            push     = 1'b1;
            push_cmd = '{kind: KIND_AUDIO, prog_num: prog_r, pid: pid_full};
          end
        end
        PH_LEN_HI: begin
          skip_nxt  = {section_byte[3:0], 8'h00};
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          skip_nxt = skip_full;
          if (skip_full != '0) begin
            phase_nxt = PH_SKIP;
          end else begin
            at_boundary = 1'b1;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase

      // Entry boundary: finish the section or expect the next entry
      if (at_boundary) begin
        if (pos_inc >= {1'b0, sec_end}) begin
          phase_nxt = PH_IDLE;
          push      = 1'b1;
          push_cmd  = '{kind: KIND_DONE, prog_num: prog_r, pid: '0};
        end else begin
          phase_nxt = PH_TYPE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      pos_r        <= '0;
      slen_r       <= '0;
      prog_r       <= '0;
      info_r       <= '0;
      type_r       <= '0;
      pid_r        <= '0;
      skip_r       <= '0;
      video_code_r <= VIDEO_CODE_RST;
      audio_code_r <= AUDIO_CODE_RST;
    end else begin
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      slen_r       <= slen_nxt;
      prog_r       <= prog_nxt;
      info_r       <= info_nxt;
      type_r       <= type_nxt;
      pid_r        <= pid_nxt;
      skip_r       <= skip_nxt;
      video_code_r <= video_code_nxt;
      audio_code_r <= audio_code_nxt;
    end
  end

endmodule

[src/pmtsp_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// pmtsp_cmd_fifo
// Short request queue between the byte parser and the program table.
// ----------------------------------------------------------------------------
module pmtsp_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pmtsp_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output pmtsp_pkg::cmd_t pop_cmd
);
  import pmtsp_pkg::*;

  localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t             mem_r [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(CMD_DEPTH));
  assign valid   = (cnt_r != '0);
  assign pop_cmd = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the request
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[src/pmtsp_back.sv]
// ----------------------------------------------------------------------------
// pmtsp_back
// Program table: drops repeated streams, records new programs, drives reports.
// ----------------------------------------------------------------------------
module pmtsp_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cmd_valid,
  input  pmtsp_pkg::cmd_t                 cmd,
  output logic                            cmd_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [pmtsp_pkg::KIND_W-1:0]    out_kind,
  output logic [pmtsp_pkg::PROG_W-1:0]    out_program,
  output logic [pmtsp_pkg::PID_W-1:0]     out_pid,
  output logic                            out_full
);
  import pmtsp_pkg::*;

  logic [PROG_W-1:0]       known_r [MAX_PROGRAMS];
  logic [MAX_PROGRAMS-1:0] vseen_r, vseen_nxt, aseen_r, aseen_nxt;
  logic [PROG_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [MAX_PROGRAMS-1:0] hit;
  logic                    hit_any, seen_any, is_video, is_stream, has_room, rec_new;
  logic [PROG_IDX_W-1:0]   new_idx;

  logic                    valid_r, valid_nxt;
  kind_t                   kind_r, kind_nxt;
  logic [PROG_W-1:0]       prog_r, prog_nxt;
  logic [PID_W-1:0]        pid_r, pid_nxt;
  logic                    full_r, full_nxt;

  // Compare every listed program in parallel; entries are unique
  always_comb begin
    for (int i = 0; i < MAX_PROGRAMS; i++) begin
      hit[i] = (PROG_CNT_W'(i) < cnt_r) && (known_r[i] == cmd.prog_num);
    end
  end

  assign is_video  = (cmd.kind == KIND_VIDEO);
  assign is_stream = (cmd.kind == KIND_VIDEO) || (cmd.kind == KIND_AUDIO);
  assign hit_any   = |hit;
  assign seen_any  = is_video ? |(hit & vseen_r) : |(hit & aseen_r);
  assign has_room  = (cnt_r != PROG_CNT_W'(MAX_PROGRAMS));
  assign new_idx   = cnt_r[PROG_IDX_W-1:0];
  assign cmd_pop   = cmd_valid && (!valid_r || out_tready);
  assign rec_new   = cmd_pop && is_stream && !hit_any && has_room;

  always_comb begin
    vseen_nxt = vseen_r;
    aseen_nxt = aseen_r;
    cnt_nxt   = cnt_r;
    valid_nxt = valid_r && !out_tready;
    kind_nxt  = kind_r;
    prog_nxt  = prog_r;
    pid_nxt   = pid_r;
    full_nxt  = full_r;

    if (cmd_pop) begin
      kind_nxt = cmd.kind;
      prog_nxt = cmd.prog_num;
      pid_nxt  = is_stream ? cmd.pid : '0;
      full_nxt = 1'b0;
      if (!is_stream) begin
        valid_nxt = 1'b1;
      end else if (hit_any) begin
        // Report only the first stream of this kind for the program
        if (!seen_any) begin
          valid_nxt = 1'b1;
          if (is_video) vseen_nxt = vseen_r | hit;
          else          aseen_nxt = aseen_r | hit;
        end
      end else if (has_room) begin
        valid_nxt          = 1'b1;
        vseen_nxt[new_idx] = is_video;
        aseen_nxt[new_idx] = !is_video;
        cnt_nxt            = cnt_r + PROG_CNT_W'(1);
      end else begin
        valid_nxt = 1'b1;
        full_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vseen_r <= '0;
      aseen_r <= '0;
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      vseen_r <= vseen_nxt;
      aseen_r <= aseen_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Hold report payload and program list
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    prog_r <= prog_nxt;
    pid_r  <= pid_nxt;
    full_r <= full_nxt;
    if (rec_new) begin
      known_r[new_idx] <= cmd.prog_num;
    end
  end

  assign out_tvalid  = valid_r;
  assign out_kind    = kind_r;
  assign out_program = prog_r;
  assign out_pid     = pid_r;
  assign out_full    = full_r;

endmodule
